/* rtl/snapshot_image_verifier_core_macros.svh */
// ----------------------------------------------------------------------------
// Snapshot image verifier assertion macros
// Clocked property checks, empty when the design is synthesised.
// ----------------------------------------------------------------------------
`ifndef SNAPSHOT_IMAGE_VERIFIER_CORE_MACROS_SVH
`define SNAPSHOT_IMAGE_VERIFIER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// check a property while out of reset
`define SIV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check a property at every edge
`define SIV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SIV_ASSERT(lbl, clk, rst_n, prop, msg)
`define SIV_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/siv_pkg.sv */
// ----------------------------------------------------------------------------
// Snapshot image verifier package
// Shared types, status codes, register indexes and SHA-256 constants.
// ----------------------------------------------------------------------------
package siv_pkg;

    localparam int HASHED_HDR_BYTES = 80;
    localparam int DIGEST_OFS       = 80;
    localparam int DIGEST_END       = 112;

    // register indexes
    localparam logic [1:0] REG_MAGIC_VALUE  = 2'd0;
    localparam logic [1:0] REG_MAGIC_LENGTH = 2'd1;
    localparam logic [1:0] REG_EXP_VERSION  = 2'd2;
    localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd3;

    // verdict codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_TOO_LARGE = 4'd1;
    localparam logic [3:0] ST_TOO_SHORT = 4'd2;
    localparam logic [3:0] ST_MAGIC     = 4'd3;
    localparam logic [3:0] ST_VERSION   = 4'd4;
    localparam logic [3:0] ST_HDR_SIZE  = 4'd5;
    localparam logic [3:0] ST_RESERVED  = 4'd6;
    localparam logic [3:0] ST_LENGTH    = 4'd7;
    localparam logic [3:0] ST_DIGEST    = 4'd8;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_ROUND   = 5'b00010,
        S_ADD     = 5'b00100,
        S_PAD     = 5'b01000,
        S_VERDICT = 5'b10000
    } t_state;

    typedef struct packed {
        logic       load_byte;
        logic       pad_byte;
        logic       init_work;
        logic       round_en;
        logic [5:0] round_idx;
        logic       add_hash;
        logic       load_verdict;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic byte_hashed;
        logic fill_end;
        logic len_phase;
    } t_sts;

    localparam logic [0:7][31:0] SHA_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

/* rtl/siv_ctrl.sv */
// ----------------------------------------------------------------------------
// Snapshot image verifier controller
// Sequences byte intake, SHA-256 rounds, padding and the verdict.
// ----------------------------------------------------------------------------
module siv_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last_byte,
    input  siv_pkg::t_sts i_sts,
    output siv_pkg::t_cmd o_cmd,
    output logic          o_in_ready
);
    import siv_pkg::*;

    t_state     r_state, n_state;
    logic [5:0] r_rnd, n_rnd;
    logic       r_last, n_last;
    logic       r_inpad, n_inpad;
    logic       r_finblk, n_finblk;
    logic       w_acc;

    // take a request only when idle and the output stage can hold a result
    assign o_in_ready = (r_state == S_IDLE) && i_sts.out_free;
    assign w_acc      = i_in_valid && o_in_ready;

    // issue commands
    always_comb begin
        o_cmd              = '0;
        o_cmd.load_byte    = w_acc;
        o_cmd.pad_byte     = (r_state == S_PAD);
        o_cmd.round_en     = (r_state == S_ROUND);
        o_cmd.round_idx    = r_rnd;
        o_cmd.add_hash     = (r_state == S_ADD);
        o_cmd.load_verdict = (r_state == S_VERDICT) && i_sts.out_free;
        o_cmd.init_work    = (w_acc && i_sts.byte_hashed && i_sts.fill_end)
                          || ((r_state == S_PAD) && i_sts.fill_end);
    end

    // advance the sequence
    always_comb begin
        n_state  = r_state;
        n_rnd    = r_rnd;
        n_last   = r_last;
        n_inpad  = r_inpad;
        n_finblk = r_finblk;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_sts.byte_hashed && i_sts.fill_end) begin
                        n_state = S_ROUND;
                        n_rnd   = '0;
                        n_last  = i_last_byte;
                    end else if (i_last_byte) begin
                        n_state = S_PAD;
                        n_inpad = 1'b1;
                    end
                end
            end
            S_ROUND: begin
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (r_finblk) begin
                    n_state = S_VERDICT;
                end else if (r_inpad || r_last) begin
                    n_state = S_PAD;
                    n_inpad = 1'b1;
                    n_last  = 1'b0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PAD: begin
                if (i_sts.fill_end) begin
                    n_state = S_ROUND;
                    n_rnd   = '0;
                    if (i_sts.len_phase) begin
                        n_finblk = 1'b1;
                    end
                end
            end
            S_VERDICT: begin
                if (i_sts.out_free) begin
                    n_state  = S_IDLE;
                    n_inpad  = 1'b0;
                    n_finblk = 1'b0;
                    n_last   = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rnd    <= '0;
            r_last   <= 1'b0;
            r_inpad  <= 1'b0;
            r_finblk <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rnd    <= n_rnd;
            r_last   <= n_last;
            r_inpad  <= n_inpad;
            r_finblk <= n_finblk;
        end
    end

endmodule

/* rtl/siv_dp.sv */
// ----------------------------------------------------------------------------
// Snapshot image verifier datapath
// Header capture, checks, SHA-256 round unit, padding and output stage.
// ----------------------------------------------------------------------------
module siv_dp #(
    parameter int HDR_SIZE = 112
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data,
    input  logic [7:0]    i_data_byte,
    input  siv_pkg::t_cmd i_cmd,
    output siv_pkg::t_sts o_sts,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic          o_item_kind,
    output logic [7:0]    o_payload_byte,
    output logic [3:0]    o_status,
    output logic [31:0]   o_hdr_version,
    output logic [63:0]   o_store_id_low,
    output logic [63:0]   o_store_id_high,
    output logic [63:0]   o_watermark,
    output logic [63:0]   o_epoch,
    output logic [63:0]   o_created_ms,
    output logic [63:0]   o_payload_length
);
    import siv_pkg::*;

    localparam logic [63:0] HDR_LEN = 64'(HDR_SIZE);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    // configuration
    logic [63:0] r_magic;
    logic [3:0]  r_mlen;
    logic [31:0] r_ver;
    logic [63:0] r_max;

    // image state
    logic [63:0]       r_bc;
    logic [63:0]       r_hlen;
    logic [5:0]        r_fill;
    logic [1:0]        r_flags;
    logic              r_padfirst;
    logic              r_lenok;
    logic [511:0]      r_blk;
    logic [447:0]      r_fld;
    logic [255:0]      r_dig;
    logic [0:7][31:0]  r_h;
    logic [0:7][31:0]  r_wk;

    // output stage
    logic        r_ovalid;
    logic        r_kind;
    logic [7:0]  r_pbyte;
    logic [3:0]  r_status;
    logic [31:0] r_o_ver;
    logic [63:0] r_o_sid_lo, r_o_sid_hi, r_o_wm, r_o_ep, r_o_cr, r_o_len;

    logic        w_hashed, w_shift, w_out_free, w_magic_bad, w_res_bad, w_payload;
    logic [7:0]  w_shift_val, w_pad_val;
    logic [3:0]  w_mlen_eff;
    logic [63:0] w_bits, w_plen;
    logic [31:0] w_w0, w_w1, w_w9, w_w14, w_wnew, w_t1, w_t2;
    logic [31:0] w_s0, w_s1, w_bs0, w_bs1, w_ch, w_maj;
    logic [3:0]  w_verdict;
    logic        w_short;

    // classify the incoming byte
    assign w_hashed  = (r_bc < 64'(HASHED_HDR_BYTES)) || (r_bc >= HDR_LEN);
    assign w_payload = (r_bc >= HDR_LEN);
    assign w_mlen_eff = (r_mlen > 4'd8) ? 4'd8 : r_mlen;
    assign w_magic_bad = (r_bc < 64'd8) && (r_bc[3:0] < w_mlen_eff)
                      && (i_data_byte != r_magic[{r_bc[2:0], 3'b000} +: 8]);
    assign w_res_bad = (r_bc >= 64'd64) && (r_bc < 64'(HASHED_HDR_BYTES))
                    && (i_data_byte != 8'd0);

    // padding byte: marker, zeros, then the bit length big-endian
    assign w_bits = {r_hlen[60:0], 3'b000};
    always_comb begin
        if (r_padfirst) begin
            w_pad_val = 8'h80;
        end else if (r_lenok && (r_fill >= 6'd56)) begin
            w_pad_val = w_bits[{~r_fill[2:0], 3'b000} +: 8];
        end else begin
            w_pad_val = 8'h00;
        end
    end

    assign w_shift     = (i_cmd.load_byte && w_hashed) || i_cmd.pad_byte;
    assign w_shift_val = i_cmd.pad_byte ? w_pad_val : i_data_byte;

    // message schedule and round function
    assign w_w0  = r_blk[511:480];
    assign w_w1  = r_blk[479:448];
    assign w_w9  = r_blk[223:192];
    assign w_w14 = r_blk[63:32];
    assign w_s0  = rotr(w_w1, 7) ^ rotr(w_w1, 18) ^ (w_w1 >> 3);
    assign w_s1  = rotr(w_w14, 17) ^ rotr(w_w14, 19) ^ (w_w14 >> 10);
    assign w_wnew = w_w0 + w_s0 + w_w9 + w_s1;
    assign w_bs1 = rotr(r_wk[4], 6) ^ rotr(r_wk[4], 11) ^ rotr(r_wk[4], 25);
    assign w_bs0 = rotr(r_wk[0], 2) ^ rotr(r_wk[0], 13) ^ rotr(r_wk[0], 22);
    assign w_ch  = (r_wk[4] & r_wk[5]) ^ (~r_wk[4] & r_wk[6]);
    assign w_maj = (r_wk[0] & r_wk[1]) ^ (r_wk[0] & r_wk[2]) ^ (r_wk[1] & r_wk[2]);
    assign w_t1  = r_wk[7] + w_bs1 + w_ch + ROUND_K[i_cmd.round_idx] + w_w0;
    assign w_t2  = w_bs0 + w_maj;

    // verdict in priority order
    assign w_short = (r_bc < HDR_LEN);
    assign w_plen  = r_bc - HDR_LEN;
    always_comb begin
        if (w_short)                         w_verdict = ST_TOO_SHORT;
        else if (w_plen > r_max)             w_verdict = ST_TOO_LARGE;
        else if (r_flags[0])                 w_verdict = ST_MAGIC;
        else if (r_fld[31:0] != r_ver)       w_verdict = ST_VERSION;
        else if (r_fld[63:32] != HDR_LEN[31:0]) w_verdict = ST_HDR_SIZE;
        else if (r_flags[1])                 w_verdict = ST_RESERVED;
        else if (w_plen != r_fld[447:384])   w_verdict = ST_LENGTH;
        else if (r_dig != r_h)               w_verdict = ST_DIGEST;
        else                                 w_verdict = ST_OK;
    end

    assign w_out_free = !r_ovalid || i_out_ready;

    always_comb begin
        o_sts             = '0;
        o_sts.out_free    = w_out_free;
        o_sts.byte_hashed = w_hashed;
        o_sts.fill_end    = (r_fill == 6'd63);
        o_sts.len_phase   = r_lenok;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= '0;
            r_mlen  <= 4'd8;
            r_ver   <= 32'd1;
            r_max   <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MAGIC_VALUE:  r_magic <= i_cfg_data;
                REG_MAGIC_LENGTH: r_mlen  <= i_cfg_data[3:0];
                REG_EXP_VERSION:  r_ver   <= i_cfg_data[31:0];
                REG_MAX_PAYLOAD:  r_max   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // image control state: counts, flags, chaining value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_verdict) begin
            r_bc       <= '0;
            r_hlen     <= '0;
            r_fill     <= '0;
            r_flags    <= '0;
            r_padfirst <= 1'b1;
            r_lenok    <= 1'b0;
            r_h        <= SHA_INIT;
        end else begin
            if (i_cmd.load_byte) begin
                if (r_bc != '1) begin
                    r_bc <= r_bc + 64'd1;
                end
                if (w_hashed) begin
                    r_hlen <= r_hlen + 64'd1;
                end
                r_flags <= r_flags | {w_res_bad, w_magic_bad};
            end
            if (w_shift) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.pad_byte && r_padfirst) begin
                r_padfirst <= 1'b0;
                r_lenok    <= (r_fill < 6'd56);
            end
            if (i_cmd.add_hash) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_wk[i];
                end
                if (!r_padfirst) begin
                    r_lenok <= 1'b1;
                end
            end
        end
    end

    // block window, header fields, stored digest, working variables
    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_blk <= {r_blk[503:0], w_shift_val};
        end else if (i_cmd.round_en) begin
            r_blk <= {r_blk[479:0], w_wnew};
        end
        if (i_cmd.load_byte && (r_bc >= 64'd8) && (r_bc < 64'd64)) begin
            r_fld <= {i_data_byte, r_fld[447:8]};
        end
        if (i_cmd.load_byte && (r_bc >= 64'(DIGEST_OFS)) && (r_bc < 64'(DIGEST_END))) begin
            r_dig <= {r_dig[247:0], i_data_byte};
        end
        if (i_cmd.init_work) begin
            r_wk <= r_h;
        end else if (i_cmd.round_en) begin
            r_wk <= {w_t1 + w_t2, r_wk[0], r_wk[1], r_wk[2],
                     r_wk[3] + w_t1, r_wk[4], r_wk[5], r_wk[6]};
        end
    end

    // output stage: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((i_cmd.load_byte && w_payload) || i_cmd.load_verdict) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte && w_payload) begin
            r_kind     <= KIND_PAYLOAD;
            r_pbyte    <= i_data_byte;
            r_status   <= ST_OK;
            r_o_ver    <= '0;
            r_o_sid_lo <= '0;
            r_o_sid_hi <= '0;
            r_o_wm     <= '0;
            r_o_ep     <= '0;
            r_o_cr     <= '0;
            r_o_len    <= '0;
        end else if (i_cmd.load_verdict) begin
            r_kind     <= KIND_VERDICT;
            r_pbyte    <= '0;
            r_status   <= w_verdict;
            r_o_ver    <= w_short ? '0 : r_fld[31:0];
            r_o_sid_lo <= w_short ? '0 : r_fld[127:64];
            r_o_sid_hi <= w_short ? '0 : r_fld[191:128];
            r_o_wm     <= w_short ? '0 : r_fld[255:192];
            r_o_ep     <= w_short ? '0 : r_fld[319:256];
            r_o_cr     <= w_short ? '0 : r_fld[383:320];
            r_o_len    <= w_short ? '0 : r_fld[447:384];
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_item_kind      = r_kind;
    assign o_payload_byte   = r_pbyte;
    assign o_status         = r_status;
    assign o_hdr_version    = r_o_ver;
    assign o_store_id_low   = r_o_sid_lo;
    assign o_store_id_high  = r_o_sid_hi;
    assign o_watermark      = r_o_wm;
    assign o_epoch          = r_o_ep;
    assign o_created_ms     = r_o_cr;
    assign o_payload_length = r_o_len;

endmodule

/* rtl/snapshot_image_verifier_core.sv */
// ----------------------------------------------------------------------------
// Snapshot image verifier core
// Parses a snapshot header, passes payload through, checks it with SHA-256.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                    Payload
// in       input      i_in_valid / o_in_ready      i_data_byte, i_last_byte
// out      output     o_out_valid / i_out_ready    o_item_kind .. o_payload_length
// cfg      input      i_cfg_we (no wait)           i_cfg_index, i_cfg_data
//
// One byte a cycle is taken while idle with a free output; a byte that
// completes a 64-byte block waits for the single round unit (64 rounds plus
// the chaining add). At the last byte padding runs one byte a cycle with one
// or two more blocks, then the verdict is loaded; only then is a byte taken.
// Reset is synchronous and active low and clears all control state.
// A stalled output holds the next request back; results are never dropped.
// ----------------------------------------------------------------------------
`include "snapshot_image_verifier_core_macros.svh"

module snapshot_image_verifier_core #(
    parameter int HDR_SIZE = 112
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_item_kind,
    output logic [7:0]  o_payload_byte,
    output logic [3:0]  o_status,
    output logic [31:0] o_hdr_version,
    output logic [63:0] o_store_id_low,
    output logic [63:0] o_store_id_high,
    output logic [63:0] o_watermark,
    output logic [63:0] o_epoch,
    output logic [63:0] o_created_ms,
    output logic [63:0] o_payload_length
);
    import siv_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    siv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_byte (i_last_byte),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_ready  (o_in_ready)
    );

    siv_dp #(
        .HDR_SIZE (HDR_SIZE)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_data_byte      (i_data_byte),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_item_kind      (o_item_kind),
        .o_payload_byte   (o_payload_byte),
        .o_status         (o_status),
        .o_hdr_version    (o_hdr_version),
        .o_store_id_low   (o_store_id_low),
        .o_store_id_high  (o_store_id_high),
        .o_watermark      (o_watermark),
        .o_epoch          (o_epoch),
        .o_created_ms     (o_created_ms),
        .o_payload_length (o_payload_length)
    );

    `SIV_ASSERT(a_no_take_when_blocked, i_clk, i_rst_n, !(o_in_ready && o_out_valid && !i_out_ready), "request taken while output stalled")
    `SIV_ASSERT(a_verdict_loaded, i_clk, i_rst_n, w_cmd.load_verdict |=> (o_out_valid && o_item_kind), "verdict not presented")
    `SIV_ASSERT(a_one_byte_source, i_clk, i_rst_n, !(w_cmd.load_byte && (w_cmd.pad_byte || w_cmd.round_en)), "byte intake overlaps hashing")
    `SIV_ASSERT(a_status_range, i_clk, i_rst_n, o_out_valid |-> (o_status <= ST_DIGEST), "status code out of range")

endmodule

/* sim/snapshot_image_verifier_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Snapshot image verifier core testbench
// Streams snapshot images (well-formed, corrupted, short and noise) through
// the core under several register settings, predicts every payload request
// and verdict with an independent SHA-256 and header parser, and compares
// each output request field by field.
// ----------------------------------------------------------------------------
module snapshot_image_verifier_core_test;
    import siv_pkg::*;

    localparam int HDR_LEN    = 112;
    localparam int WDOG_LIMIT = 6000;
    localparam int SETTLE     = 300;

    // image corruption kinds
    typedef enum int {
        IMG_GOOD, IMG_BAD_MAGIC, IMG_BAD_VERSION, IMG_BAD_HDR_SIZE, IMG_BAD_RESERVED,
        IMG_BAD_LENGTH, IMG_BAD_DIGEST, IMG_TRUNCATED, IMG_NOISE
    } t_img_kind;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_byte_req;

    typedef struct {
        logic        kind;
        logic [7:0]  pbyte;
        logic [3:0]  status;
        logic [31:0] version;
        logic [63:0] sid_lo;
        logic [63:0] sid_hi;
        logic [63:0] watermark;
        logic [63:0] epoch;
        logic [63:0] created;
        logic [63:0] plen;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_item_kind;
    logic [7:0]  o_payload_byte;
    logic [3:0]  o_status;
    logic [31:0] o_hdr_version;
    logic [63:0] o_store_id_low;
    logic [63:0] o_store_id_high;
    logic [63:0] o_watermark;
    logic [63:0] o_epoch;
    logic [63:0] o_created_ms;
    logic [63:0] o_payload_length;

    snapshot_image_verifier_core u_dut (.*);

    // register copies
    logic [63:0] magic_reg;
    logic [3:0]  magic_len_reg;
    logic [31:0] version_reg;
    logic [63:0] max_payload_reg;

    // parser state
    int          img_pos;
    logic [7:0]  hdr_mem[HDR_LEN];
    byte unsigned hashed_bytes[$];
    logic        magic_bad;
    logic        resv_bad;

    t_byte_req   byte_q[$];
    t_result     result_q[$];
    logic        in_taken;
    int          fail_cnt;
    int          results_seen;
    int          idle_cycles;
    int          burst_left;
    int          gap_left;
    int          hold_left;
    logic        hold_done;
    int          rx_mode;
    int          rx_mode_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [255:0] sha_compress(logic [255:0] hv, logic [511:0] blk);
        logic [31:0] w[64];
        logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
        for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        {a, b, c, d, e, f, g, hh} = hv;
        for (int i = 0; i < 64; i++) begin
            t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_K[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            hh = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        return {hv[255:224] + a, hv[223:192] + b, hv[191:160] + c, hv[159:128] + d,
                hv[127:96] + e, hv[95:64] + f, hv[63:32] + g, hv[31:0] + hh};
    endfunction

    // pad the message and run every block
    function automatic logic [255:0] sha_digest(byte unsigned msg[$]);
        byte unsigned m[$];
        logic [255:0] hv;
        logic [511:0] blk;
        logic [63:0]  bits;
        m = msg;
        bits = 64'(msg.size()) << 3;
        hv = SHA_INIT;
        m.push_back(8'h80);
        while (m.size() % 64 != 56) m.push_back(8'h00);
        for (int k = 7; k >= 0; k--) m.push_back(bits[8 * k +: 8]);
        for (int base = 0; base < m.size(); base += 64) begin
            for (int j = 0; j < 64; j++) blk[511 - 8 * j -: 8] = m[base + j];
            hv = sha_compress(hv, blk);
        end
        return hv;
    endfunction

    function automatic logic [63:0] hdr_le(int ofs, int n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++) v[8 * i +: 8] = hdr_mem[ofs + i];
        return v;
    endfunction

    // advance the parser by one accepted byte and queue the results it causes
    task automatic predict_byte(logic [7:0] v, logic last);
        t_result     r;
        logic [255:0] dg;
        logic [63:0] plen;
        int          mlen;
        r = '{default: '0};
        mlen = (magic_len_reg > 8) ? 8 : magic_len_reg;
        if (img_pos < HDR_LEN) begin
            hdr_mem[img_pos] = v;
            if (img_pos < mlen && v != magic_reg[8 * img_pos +: 8]) magic_bad = 1'b1;
            if (img_pos >= 64 && img_pos < 80 && v != 8'h00) resv_bad = 1'b1;
            if (img_pos < HASHED_HDR_BYTES) hashed_bytes.push_back(v);
        end else begin
            hashed_bytes.push_back(v);
            r.kind  = KIND_PAYLOAD;
            r.pbyte = v;
            result_q.push_back(r);
        end
        img_pos++;
        if (last) begin
            r = '{default: '0};
            r.kind = KIND_VERDICT;
            if (img_pos < HDR_LEN) begin
                r.status = ST_TOO_SHORT;
            end else begin
                plen        = 64'(img_pos - HDR_LEN);
                r.version   = hdr_le(8, 4);
                r.sid_lo    = hdr_le(16, 8);
                r.sid_hi    = hdr_le(24, 8);
                r.watermark = hdr_le(32, 8);
                r.epoch     = hdr_le(40, 8);
                r.created   = hdr_le(48, 8);
                r.plen      = hdr_le(56, 8);
                dg = sha_digest(hashed_bytes);
                if (plen > max_payload_reg) r.status = ST_TOO_LARGE;
                else if (magic_bad) r.status = ST_MAGIC;
                else if (r.version != version_reg) r.status = ST_VERSION;
                else if (hdr_le(12, 4) != 64'(HDR_LEN)) r.status = ST_HDR_SIZE;
                else if (resv_bad) r.status = ST_RESERVED;
                else if (plen != r.plen) r.status = ST_LENGTH;
                else begin
                    r.status = ST_OK;
                    for (int i = 0; i < 32; i++)
                        if (dg[255 - 8 * i -: 8] != hdr_mem[DIGEST_OFS + i])
                            r.status = ST_DIGEST;
                end
            end
            result_q.push_back(r);
            img_pos   = 0;
            magic_bad = 1'b0;
            resv_bad  = 1'b0;
            hashed_bytes.delete();
        end
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    // build one image and queue its bytes
    task automatic make_image(t_img_kind kind, int plen);
        byte unsigned img[$];
        byte unsigned msg[$];
        logic [255:0] dg;
        int           len;
        for (int i = 0; i < HDR_LEN; i++) img.push_back(8'h00);
        for (int i = 0; i < 8; i++) img[i] = magic_reg[8 * i +: 8];
        for (int i = 0; i < 4; i++) img[8 + i] = version_reg[8 * i +: 8];
        img[12] = 8'(HDR_LEN);
        for (int i = 16; i < 56; i++) img[i] = 8'($urandom);
        for (int i = 0; i < 8; i++) img[56 + i] = 8'(64'(plen) >> (8 * i));
        for (int i = 0; i < plen; i++) img.push_back(8'($urandom));
        case (kind)
            IMG_BAD_MAGIC:    img[$urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
            IMG_BAD_VERSION:  img[8 + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
            IMG_BAD_HDR_SIZE: img[12 + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
            IMG_BAD_RESERVED: img[64 + $urandom_range(0, 15)] = 8'($urandom_range(1, 255));
            IMG_BAD_LENGTH:   img[56 + $urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
            default: ;
        endcase
        for (int i = 0; i < HASHED_HDR_BYTES; i++) msg.push_back(img[i]);
        for (int i = HDR_LEN; i < img.size(); i++) msg.push_back(img[i]);
        dg = sha_digest(msg);
        for (int i = 0; i < 32; i++) img[DIGEST_OFS + i] = dg[255 - 8 * i -: 8];
        if (kind == IMG_BAD_DIGEST) begin
            if (plen > 0 && $urandom_range(0, 1)) img[HDR_LEN + $urandom_range(0, plen - 1)] ^= 8'h01;
            else img[DIGEST_OFS + $urandom_range(0, 31)] ^= 8'(1 << $urandom_range(0, 7));
        end
        len = img.size();
        if (kind == IMG_TRUNCATED) len = $urandom_range(1, HDR_LEN - 1);
        if (kind == IMG_NOISE) begin
            len = $urandom_range(1, 200);
            img.delete();
            for (int i = 0; i < len; i++) img.push_back(8'($urandom));
        end
        for (int i = 0; i < len; i++) byte_q.push_back('{img[i], i == len - 1});
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_MAGIC_VALUE:  magic_reg       = val;
            REG_MAGIC_LENGTH: magic_len_reg   = val[3:0];
            REG_EXP_VERSION:  version_reg     = val[31:0];
            default:          max_payload_reg = val;
        endcase
    endtask

    task automatic set_regs(logic [63:0] mv, logic [3:0] ml, logic [31:0] ver,
                            logic [63:0] maxp);
        write_reg(REG_MAGIC_VALUE, mv);
        write_reg(REG_MAGIC_LENGTH, {60'd0, ml});
        write_reg(REG_EXP_VERSION, {32'd0, ver});
        write_reg(REG_MAX_PAYLOAD, maxp);
    endtask

    // wait for the core to drain, then let any padding pass settle
    task automatic drain();
        while (byte_q.size() != 0 || i_in_valid || result_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    function automatic int pick_plen();
        if ($urandom_range(0, 9) == 0) return $urandom_range(60, 140);
        return $urandom_range(0, 48);
    endfunction

    // input requests: bursts with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // hold the pending request
        end else if (gap_left != 0) begin
            i_in_valid <= 1'b0;
            gap_left--;
        end else if (byte_q.size() != 0) begin
            i_in_valid  <= 1'b1;
            i_data_byte <= byte_q[0].data;
            i_last_byte <= byte_q[0].last;
            void'(byte_q.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 60);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // output stalls: mode pattern plus one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (!hold_done && results_seen >= 5) begin
                hold_left = 800;
                hold_done = 1'b1;
            end
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(20, 120);
            end
            rx_mode_left--;
            if (hold_left != 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                case (rx_mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= $urandom_range(0, 1);
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // sample handshakes, predict, compare, watch for a hang
    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n) begin
            in_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) predict_byte(i_data_byte, i_last_byte);
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d status %0d",
                             $time, o_item_kind, o_status);
                    fail_cnt++;
                end else begin
                    r = result_q.pop_front();
                    check_field("item_kind", r.kind, o_item_kind);
                    check_field("payload_byte", r.pbyte, o_payload_byte);
                    check_field("status", r.status, o_status);
                    check_field("hdr_version", r.version, o_hdr_version);
                    check_field("store_id_low", r.sid_lo, o_store_id_low);
                    check_field("store_id_high", r.sid_hi, o_store_id_high);
                    check_field("watermark", r.watermark, o_watermark);
                    check_field("epoch", r.epoch, o_epoch);
                    check_field("created_ms", r.created, o_created_ms);
                    check_field("payload_length", r.plen, o_payload_length);
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("[snapshot_image_verifier_core] ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_in_valid = 1'b0; i_data_byte = '0; i_last_byte = 1'b0; i_out_ready = 1'b0;
        magic_reg = '0; magic_len_reg = 4'd8; version_reg = 32'd1; max_payload_reg = '1;
        img_pos = 0; magic_bad = 1'b0; resv_bad = 1'b0; in_taken = 1'b0;
        fail_cnt = 0; results_seen = 0; idle_cycles = 0;
        burst_left = 8; gap_left = 0; hold_left = 0; hold_done = 1'b0;
        rx_mode = 0; rx_mode_left = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (SETTLE) @(negedge i_clk);

        // reset settings: one image per check, short images, padding that spills
        make_image(IMG_GOOD, 45);
        make_image(IMG_TRUNCATED, 0);
        byte_q.push_back('{8'hff, 1'b1});
        for (t_img_kind k = IMG_BAD_MAGIC; k <= IMG_BAD_DIGEST; k = t_img_kind'(k + 1))
            make_image(k, 3);
        drain();

        // extreme register values
        set_regs('1, 4'd15, '1, 64'd0);
        make_image(IMG_GOOD, 0);
        make_image(IMG_GOOD, 1);
        drain();
        set_regs(64'h0123456789abcdef, 4'd0, 32'd0, 64'd10);
        make_image(IMG_GOOD, 10);
        make_image(IMG_GOOD, 11);
        drain();

        // random phase
        for (int ph = 0; ph < 1; ph++) begin
            set_regs({$urandom, $urandom}, 4'($urandom_range(0, 15)), $urandom,
                     ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 60)) : '1);
            for (int n = 0; n < 1; n++)
                make_image(($urandom_range(0, 1) == 0) ? IMG_GOOD
                           : t_img_kind'($urandom_range(0, 8)), pick_plen());
            drain();
        end

        if (fail_cnt == 0) begin
            $display("[snapshot_image_verifier_core] OK");
        end else begin
            $display("[snapshot_image_verifier_core] ERROR");
        end
        $finish;
    end

endmodule
